@@ hw/rtl/ckbm_pkg.sv @@
// shared types and constants for the color key blit with mirror
package ckbm_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_PITCH  = 1023;

    localparam int KEY_W    = 8;
    localparam int WIDTH_W  = 10;
    localparam int HEIGHT_W = 9;
    localparam int PITCH_W  = 10;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int ADDR_W   = 18;
    localparam int PIX_W    = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 48;

    localparam logic [KEY_W-1:0] KEY_RESET = 8'd10;

    typedef enum logic [1:0] {
        PART_TOP      = 2'd0,
        PART_LEFT     = 2'd1,
        PART_MIRROR   = 2'd2,
        PART_RESERVED = 2'd3
    } t_part;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY       = 8'd0,
        REG_PART      = 8'd1,
        REG_WIDTH     = 8'd2,
        REG_HEIGHT    = 8'd3,
        REG_SRC_PITCH = 8'd4,
        REG_DST_PITCH = 8'd5
    } t_reg_idx;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        t_part               part;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [PITCH_W-1:0]  dst_pitch;
        logic                bad;
        logic                restart;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              enable;
        logic [ADDR_W-1:0] copied;
        logic              last;
        logic              error;
    } t_result;

endpackage

@@ hw/rtl/ckbm_cfg.sv @@
// configuration registers and setup validity check
module ckbm_cfg
    import ckbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    logic [KEY_W-1:0]    r_key;
    t_part               r_part;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [PITCH_W-1:0]  r_src_pitch;
    logic [PITCH_W-1:0]  r_dst_pitch;
    logic                bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= KEY_RESET;
            r_part      <= PART_TOP;
            r_width     <= '0;
            r_height    <= '0;
            r_src_pitch <= '0;
            r_dst_pitch <= '0;
        end else if (i_wr) begin
            case (i_idx)
                REG_KEY:       r_key       <= i_data[KEY_W-1:0];
                REG_PART:      r_part      <= t_part'(i_data[1:0]);
                REG_WIDTH:     r_width     <= i_data[WIDTH_W-1:0];
                REG_HEIGHT:    r_height    <= i_data[HEIGHT_W-1:0];
                REG_SRC_PITCH: r_src_pitch <= i_data[PITCH_W-1:0];
                REG_DST_PITCH: r_dst_pitch <= i_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        bad = 1'b0;
        if (r_width == '0 || r_width > WIDTH_W'(MAX_WIDTH)) bad = 1'b1;
        if (r_height == '0 || r_height > HEIGHT_W'(MAX_HEIGHT)) bad = 1'b1;
        if (r_src_pitch < r_width || r_src_pitch > PITCH_W'(MAX_PITCH)) bad = 1'b1;
        if (r_dst_pitch < r_width || r_dst_pitch > PITCH_W'(MAX_PITCH)) bad = 1'b1;
        if (r_part == PART_RESERVED) bad = 1'b1;
    end

    assign o_cfg.key       = r_key;
    assign o_cfg.part      = r_part;
    assign o_cfg.width     = r_width;
    assign o_cfg.height    = r_height;
    assign o_cfg.dst_pitch = r_dst_pitch;
    assign o_cfg.bad       = bad;
    assign o_cfg.restart   = i_wr;

endmodule

@@ hw/rtl/ckbm_core.sv @@
// raster position state and per pixel address, enable and count logic
module ckbm_core
    import ckbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_fire,
    input  logic [PIX_W-1:0] i_pixel,
    output t_result          o_res
);

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_count;

    logic [COL_W-1:0]   col;
    logic [WIDTH_W-1:0] w_m1;
    logic               enable;
    logic               row_end;
    logic               last;
    logic [ADDR_W-1:0]  count_inc;

    assign w_m1      = i_cfg.width - WIDTH_W'(1);
    assign enable    = (i_pixel != i_cfg.key);
    assign count_inc = enable ? r_count + ADDR_W'(1) : r_count;
    assign row_end   = ({1'b0, r_col} + WIDTH_W'(1)) >= i_cfg.width;
    assign last      = row_end && (({1'b0, r_row} + HEIGHT_W'(1)) >= i_cfg.height);

    always_comb begin
        col = r_col;
        if ({1'b0, r_col} >= i_cfg.width) col = w_m1[COL_W-1:0];
        if (i_cfg.part == PART_MIRROR) col = w_m1[COL_W-1:0] - col;
    end

    always_comb begin
        if (i_cfg.bad) begin
            o_res.addr   = '0;
            o_res.pixel  = '0;
            o_res.enable = 1'b0;
            o_res.copied = r_count;
            o_res.last   = 1'b0;
            o_res.error  = 1'b1;
        end else begin
            o_res.addr   = r_base + ADDR_W'(col);
            o_res.pixel  = i_pixel;
            o_res.enable = enable;
            o_res.copied = count_inc;
            o_res.last   = last;
            o_res.error  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_count <= '0;
        end else if (i_fire && !i_cfg.bad) begin
            if (last) begin
                r_col   <= '0;
                r_row   <= '0;
                r_base  <= '0;
                r_count <= '0;
            end else if (row_end) begin
                r_col   <= '0;
                r_row   <= r_row + ROW_W'(1);
                r_base  <= r_base + ADDR_W'(i_cfg.dst_pitch);
                r_count <= count_inc;
            end else begin
                r_col   <= r_col + COL_W'(1);
                r_count <= count_inc;
            end
        end
    end

endmodule

@@ hw/rtl/ckbm_out.sv @@
// result register with skid stage
module ckbm_out
    import ckbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    fire;

    assign o_ready = !r_skid_valid;
    assign fire    = i_valid && !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_main_valid) begin
            r_main_valid <= r_skid_valid || fire;
            r_skid_valid <= 1'b0;
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end else if (fire) begin
            r_skid <= i_res;
        end
    end

endmodule

@@ hw/rtl/color_key_blit_with_mirror.sv @@
// top level of the color key transparent blit with horizontal mirror
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata src_pixel
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata, tlast, tuser
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// one pixel per cycle while m_axis accepts; each transaction's result is registered
// a skid stage keeps s_axis_tready high for one more transaction when m_axis stalls
// reset clears the position counters and loads the register reset values
// any configuration write restarts the rectangle
module color_key_blit_with_mirror
    import ckbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // src_pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // write_address, write_pixel, write_enable, copied_total, zero fill
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,   // last_pixel
    output logic                   m_axis_tuser,   // setup_error
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    in_fire;
    logic    cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    ckbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ckbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (in_fire),
        .i_pixel (s_axis_tdata[PIX_W-1:0]),
        .o_res   (core_res)
    );

    ckbm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_res   (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {3'b000, out_res.copied, out_res.enable, out_res.pixel, out_res.addr};
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = out_res.error;

endmodule

@@ test/tb_color_key_blit_with_mirror.sv @@
`timescale 1ns / 1ps
// self-checking testbench: directed and random pixel streams and setups against a cycle-free blit predictor
module tb_color_key_blit_with_mirror;
    import ckbm_pkg::*;

    localparam int REG_COUNT   = 6;
    localparam int ITEM_GOAL   = 1700;
    localparam int CALM_ITEMS  = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor registers and rectangle position
    logic [KEY_W-1:0]    cfg_key = KEY_RESET;
    t_part               cfg_part = PART_TOP;
    logic [WIDTH_W-1:0]  cfg_width = '0;
    logic [HEIGHT_W-1:0] cfg_height = '0;
    logic [PITCH_W-1:0]  cfg_src_pitch = '0;
    logic [PITCH_W-1:0]  cfg_dst_pitch = '0;
    logic [COL_W-1:0]    pos_col = '0;
    logic [ROW_W-1:0]    pos_row = '0;
    logic [ADDR_W-1:0]   pos_row_base = '0;
    logic [ADDR_W-1:0]   pos_copied = '0;

    logic [PIX_W-1:0] src_pixel_q[$];
    t_result          blit_expect_q[$];

    int unsigned idle_pct = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    bit          src_taken = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    color_key_blit_with_mirror dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void restart_rect();
        pos_col      = '0;
        pos_row      = '0;
        pos_row_base = '0;
        pos_copied   = '0;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_KEY:       cfg_key = val[KEY_W-1:0];
            REG_PART:      cfg_part = t_part'(val[1:0]);
            REG_WIDTH:     cfg_width = val[WIDTH_W-1:0];
            REG_HEIGHT:    cfg_height = val[HEIGHT_W-1:0];
            REG_SRC_PITCH: cfg_src_pitch = val[PITCH_W-1:0];
            REG_DST_PITCH: cfg_dst_pitch = val[PITCH_W-1:0];
            default: ;
        endcase
        restart_rect();
    endfunction

    function automatic t_result blit_pixel(logic [PIX_W-1:0] pix);
        t_result r;
        int      c;
        bit      bad;
        bit      row_end;
        bit      rect_end;
        r = '0;
        bad = cfg_width == 0 || cfg_width > MAX_WIDTH
            || cfg_height == 0 || cfg_height > MAX_HEIGHT
            || cfg_src_pitch < cfg_width || cfg_src_pitch > MAX_PITCH
            || cfg_dst_pitch < cfg_width || cfg_dst_pitch > MAX_PITCH
            || cfg_part == PART_RESERVED;
        if (bad) begin
            r.copied = pos_copied;
            r.error  = 1'b1;
            return r;
        end
        c = pos_col;
        if (c >= int'(cfg_width)) c = int'(cfg_width) - 1;
        if (cfg_part == PART_MIRROR) c = int'(cfg_width) - 1 - c;
        r.addr   = pos_row_base + ADDR_W'(c);
        r.pixel  = pix;
        r.enable = (pix != cfg_key);
        if (r.enable) pos_copied = pos_copied + 1'b1;
        r.copied = pos_copied;
        row_end  = int'(pos_col) + 1 >= int'(cfg_width);
        rect_end = row_end && (int'(pos_row) + 1 >= int'(cfg_height));
        r.last   = rect_end;
        if (rect_end) begin
            restart_rect();
        end else if (row_end) begin
            pos_col      = '0;
            pos_row      = pos_row + 1'b1;
            pos_row_base = pos_row_base + ADDR_W'(cfg_dst_pitch);
        end else begin
            pos_col = pos_col + 1'b1;
        end
        return r;
    endfunction

    // source side: prediction on each accepted pixel
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            blit_expect_q.push_back(blit_pixel(s_axis_tdata));
            src_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || src_taken) begin
            if (src_gap == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
                src_gap = $urandom_range(1, 11);
            if (src_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap--;
            end else if (src_pixel_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= src_pixel_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        src_taken = 1'b0;
    end

    // result side
    always @(negedge i_clk) begin
        if (sink_gap == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            sink_gap = $urandom_range(1, 11);
        if (sink_gap > 0) begin
            m_axis_tready <= 1'b0;
            sink_gap--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        logic [2:0] pad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.addr   = m_axis_tdata[ADDR_W-1:0];
            got.pixel  = m_axis_tdata[ADDR_W +: PIX_W];
            got.enable = m_axis_tdata[ADDR_W+PIX_W];
            got.copied = m_axis_tdata[ADDR_W+PIX_W+1 +: ADDR_W];
            got.last   = m_axis_tlast;
            got.error  = m_axis_tuser;
            pad        = m_axis_tdata[TDATA_OUT_W-1:2*ADDR_W+PIX_W+1];
            if (blit_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t unexpected transaction: addr %0d pix %0h en %0b copied %0d",
                             $realtime, got.addr, got.pixel, got.enable, got.copied);
            end else begin
                want = blit_expect_q.pop_front();
                if (got !== want || pad !== 3'b000) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t mismatch exp addr %0d pix %0h en %0b copied %0d last %0b err %0b",
                                 $realtime, want.addr, want.pixel, want.enable,
                                 want.copied, want.last, want.error);
                        $display("    got addr %0d pix %0h en %0b copied %0d last %0b err %0b pad %0h",
                                 got.addr, got.pixel, got.enable, got.copied, got.last,
                                 got.error, pad);
                    end
                end
            end
        end
    end

    // watchdog on stretches with no transaction anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg_write(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry random junk
    task automatic load_setup(input logic [KEY_W-1:0] key, input t_part part,
                              input int w, input int h, input int sp, input int dp);
        cfg_write(REG_KEY, {8'($urandom), key});
        cfg_write(REG_PART, {14'($urandom), part});
        cfg_write(REG_WIDTH, {6'($urandom), 10'(w)});
        cfg_write(REG_HEIGHT, {7'($urandom), 9'(h)});
        cfg_write(REG_SRC_PITCH, {6'($urandom), 10'(sp)});
        cfg_write(REG_DST_PITCH, {6'($urandom), 10'(dp)});
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            src_pixel_q.push_back(($urandom_range(0, 3) == 0) ? cfg_key : 8'($urandom));
        pixels_sent += n;
    endtask

    task automatic drain();
        while (src_pixel_q.size() != 0 || s_axis_tvalid || blit_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int pick_pitch(int w);
        case ($urandom_range(0, 3))
            0: return w;
            1: return w + $urandom_range(1, 7);
            2: return $urandom_range(w, MAX_PITCH);
            default: return MAX_PITCH;
        endcase
    endfunction

    initial begin : stimulus
        int w;
        int h;
        int n;
        int cut;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // reset setup has zero sizes
        src_pixel_q.push_back(8'h00);
        src_pixel_q.push_back(8'hFF);
        drain();

        load_setup(8'h00, PART_TOP, 3, 2, 3, 5);
        src_pixel_q.push_back(8'h00);
        src_pixel_q.push_back(8'hFF);
        src_pixel_q.push_back(8'h0A);
        src_pixel_q.push_back(8'h55);
        src_pixel_q.push_back(8'hAA);
        src_pixel_q.push_back(8'h00);
        drain();

        load_setup(8'hFF, PART_MIRROR, 2, 2, MAX_PITCH, MAX_PITCH);
        src_pixel_q.push_back(8'h01);
        src_pixel_q.push_back(8'hFF);
        src_pixel_q.push_back(8'h80);
        src_pixel_q.push_back(8'h7F);
        drain();

        // single pixel rectangle, keyed out
        load_setup(KEY_RESET, PART_LEFT, 1, 1, 1, 1);
        src_pixel_q.push_back(KEY_RESET);
        drain();

        // bad setups
        load_setup(8'h11, PART_RESERVED, 4, 4, 4, 4);
        push_random(1);
        drain();
        load_setup(8'h11, PART_TOP, MAX_WIDTH + 1, 1, MAX_PITCH, MAX_PITCH);
        push_random(1);
        drain();
        load_setup(8'h11, PART_TOP, 1, MAX_HEIGHT + 1, 1, 1);
        push_random(1);
        drain();
        load_setup(8'h11, PART_TOP, 4, 1, 3, 4);
        push_random(1);
        drain();
        load_setup(8'h11, PART_TOP, 4, 1, 4, 3);
        push_random(1);
        drain();

        // write past the register list restarts the rectangle
        load_setup(8'h33, PART_TOP, 2, 2, 2, 2);
        push_random(2);
        drain();
        cfg_write(8'hFF, 16'hFFFF);
        push_random(2);
        drain();

        // widest row and tallest column
        idle_pct = 10;
        load_setup(8'($urandom), PART_MIRROR, MAX_WIDTH, 1, MAX_PITCH, MAX_WIDTH);
        push_random(MAX_WIDTH);
        drain();
        load_setup(8'($urandom), PART_TOP, 1, MAX_HEIGHT, 1, MAX_PITCH);
        push_random(MAX_HEIGHT);
        drain();

        while (pixels_sent < ITEM_GOAL) begin
            if (pixels_sent > ITEM_GOAL - CALM_ITEMS) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < REG_COUNT; i++) cfg_write(CFG_IDX_W'(i), 16'($urandom));
                push_random($urandom_range(1, 6));
                drain();
            end else begin
                w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = $urandom_range(1, 5);
                load_setup(8'($urandom), t_part'(2'($urandom_range(PART_TOP, PART_MIRROR))),
                           w, h, pick_pitch(w), pick_pitch(w));
                n = w * h * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, n);
                    push_random(cut);
                    drain();
                    cfg_write(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), 16'($urandom));
                    n -= cut;
                end
                if ($urandom_range(0, 2) == 0) n += $urandom_range(0, w * h - 1);
                push_random(n);
                drain();
            end
        end

        idle_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && blit_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
